@@ hdl/i2cm_pkg.sv @@
// Package for the I2C master transaction engine: beat types, phase codes and constants.
// No dependencies.
package i2cm_pkg;

   localparam int BUF_DEPTH = 128;
   localparam int BUF_AW = $clog2(BUF_DEPTH);
   localparam logic [7:0] BUF_DEPTH_B = 8'(BUF_DEPTH);
   localparam logic [7:0] ACK_TIMEOUT_RST = 8'd50;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_LOAD = 2'd1,
      FUNC_START = 2'd2,
      FUNC_NOP = 2'd3
   } func_type;

   typedef enum logic [0:0] {
      CSR_DELAY = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0, PH_SW_SETUP = 5'd1, PH_SW_FALL = 5'd2, PH_R_PREP = 5'd3,
      PH_SR_SETUP = 5'd4, PH_SR_FALL = 5'd5, PH_RX_LOW = 5'd6, PH_RX_HIGH = 5'd7,
      PH_AW_TXL = 5'd8, PH_AW_TXH = 5'd9, PH_AW_ACKL = 5'd10, PH_AW_WAIT = 5'd11,
      PH_AW_HOLD = 5'd12,
      PH_D_TXL = 5'd13, PH_D_TXH = 5'd14, PH_D_ACKL = 5'd15, PH_D_WAIT = 5'd16,
      PH_D_HOLD = 5'd17,
      PH_AR_TXL = 5'd18, PH_AR_TXH = 5'd19, PH_AR_ACKL = 5'd20, PH_AR_WAIT = 5'd21,
      PH_AR_HOLD = 5'd22,
      PH_MACK_LOW = 5'd23, PH_MACK_HIGH = 5'd24, PH_STOP_LOW = 5'd25,
      PH_STOP_HIGH = 5'd26, PH_STOP_RISE = 5'd27
   } phase_type;

   typedef struct packed {
      logic [1:0] func;
      logic       sda_in;
      logic [7:0] data_byte;
      logic [6:0] dev_addr;
      logic [7:0] wr_count;
      logic [7:0] rd_count;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [7:0] delay_ticks;
      logic [7:0] ack_timeout;
   } cfg_type;

endpackage

@@ hdl/i2c_master_transaction_engine.sv @@
// Top level of the I2C master transaction engine: front queue, sequencer and CSRs.
// Depends on i2cm_pkg, i2cm_queue and i2cm_seq.
//
//   channel   direction  handshake           beat
//   req_      in         push / full         req_type
//   rsp_      out        empty / pop         rsp_type
//   csr_      in         valid / ready       index and 8-bit data
//
// One request beat is handled per cycle while responses are popped; each gives one response
// beat, which passes the queue slot and then the result register before it is on rsp_data.
// The sequencer moves at most one bus phase per tick beat: a phase lasts delay_ticks
// ticks (one tick when delay_ticks is zero), and ACK waits poll SDA on every tick.
// A waiting response stalls the sequencer, which fills the two-entry queue and raises
// req_full. Synchronous reset idles the sequencer and restores delay 1, timeout 50.
module i2c_master_transaction_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  i2cm_pkg::req_type  req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output i2cm_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import i2cm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type q_data;
   logic    q_empty, q_take, out_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DELAY: cfg_in.delay_ticks = csr_data;
            CSR_TIMEOUT: cfg_in.ack_timeout = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_ticks <= 8'd1;
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cm_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_push), .push_data(req_data), .full(req_full),
      .pop(q_take), .pop_data(q_data), .empty(q_empty)
   );

   i2cm_seq u_seq (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(!q_empty), .in_data(q_data), .in_take(q_take),
      .out_valid(out_valid), .out_data(rsp_data), .out_take(rsp_pop)
   );

   assign rsp_empty = !out_valid;
endmodule

@@ hdl/i2cm_queue.sv @@
// Two-entry beat queue between the front and the back of the engine.
// Depends on i2cm_pkg.
module i2cm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  i2cm_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output i2cm_pkg::req_type pop_data,
   output logic             empty
);
   import i2cm_pkg::*;

   req_type    slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |=> count_ff == 2'd2 || count_ff == 2'd1) else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count");
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      empty |=> count_ff != 2'd3) else $error("queue count range");
endmodule

@@ hdl/i2cm_seq.sv @@
// Back part: bit-level I2C sequencer, write buffer memory and the result register.
// Depends on i2cm_pkg.
module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  i2cm_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  i2cm_pkg::req_type  in_data,
   output logic              in_take,
   output logic              out_valid,
   output i2cm_pkg::rsp_type  out_data,
   input  logic              out_take
);
   import i2cm_pkg::*;

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] mem_rd_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] delay_ff, delay_in, byte_ff, byte_in, shift_ff, shift_in;
   logic [7:0] wait_ff, wait_in, fill_ff, fill_in, wtot_ff, wtot_in, rtot_ff, rtot_in;
   logic [3:0] bit_ff, bit_in;
   logic [6:0] addr_ff, addr_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;

   logic       step, fire, mem_we, pre_rd, rd_ok;
   logic [7:0] limit, dcount;
   logic [7:0] rd_addr;
   logic [2:0] pins;
   logic [7:0] wlen;

   assign in_take = in_valid && (!rsp_valid_ff || out_take);
   assign step = in_take;
   assign out_valid = rsp_valid_ff;
   assign out_data = rsp_ff;

   // The buffer is read one step ahead: during the ACK wait and hold of a byte the
   // address is the index of the next byte to send, so the data is ready when the hold ends.
   always_comb begin
      rd_addr = (phase_ff == PH_D_WAIT || phase_ff == PH_D_HOLD) ? byte_ff + 8'd1 : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we && step) begin
         mem[fill_ff[BUF_AW-1:0]] <= in_data.data_byte;
      end
      mem_rd_ff <= mem[rd_addr[BUF_AW-1:0]];
   end

   always_comb begin
      phase_in = phase_ff;
      delay_in = delay_ff;
      byte_in = byte_ff;
      shift_in = shift_ff;
      wait_in = wait_ff;
      fill_in = fill_ff;
      wtot_in = wtot_ff;
      rtot_in = rtot_ff;
      bit_in = bit_ff;
      addr_in = addr_ff;
      mem_we = 1'b0;
      rsp_in = '0;
      fire = 1'b0;
      limit = (cfg.delay_ticks == 8'd0) ? 8'd1 : cfg.delay_ticks;
      dcount = delay_ff + 8'd1;
      wlen = (in_data.wr_count > BUF_DEPTH_B) ? BUF_DEPTH_B : in_data.wr_count;
      pre_rd = 1'b0;
      rd_ok = byte_ff < wtot_ff;
      case (in_data.func)
         FUNC_LOAD: begin
            if (phase_ff == PH_IDLE && fill_ff < BUF_DEPTH_B) begin
               mem_we = 1'b1;
               fill_in = fill_ff + 8'd1;
            end
         end
         FUNC_START: begin
            if (phase_ff == PH_IDLE) begin
               addr_in = in_data.dev_addr;
               wtot_in = wlen;
               rtot_in = in_data.rd_count;
               delay_in = 8'd0;
               bit_in = 4'd0;
               byte_in = 8'd0;
               shift_in = 8'd0;
               wait_in = 8'd0;
               phase_in = PH_SW_SETUP;
            end
         end
         FUNC_TICK: begin
            if (phase_ff == PH_AW_WAIT || phase_ff == PH_D_WAIT
                || phase_ff == PH_AR_WAIT) begin
               if (!in_data.sda_in) begin
                  wait_in = 8'd0;
                  delay_in = 8'd0;
                  phase_in = phase_type'(phase_ff + 5'd1);
               end else if (wait_ff >= cfg.ack_timeout) begin
                  wait_in = 8'd0;
                  delay_in = 8'd0;
                  phase_in = PH_STOP_LOW;
                  shift_in = (phase_ff == PH_AW_WAIT) ? 8'd1 :
                             (phase_ff == PH_D_WAIT) ? 8'd2 : 8'd3;
               end else begin
                  wait_in = wait_ff + 8'd1;
               end
            end else if (phase_ff != PH_IDLE) begin
               if (dcount < limit) begin
                  delay_in = dcount;
               end else begin
                  delay_in = 8'd0;
                  fire = 1'b1;
               end
            end
         end
         default: ;
      endcase

      if (fire) begin
         case (phase_ff)
            PH_SW_SETUP: phase_in = PH_SW_FALL;
            PH_SW_FALL: begin
               shift_in = {addr_ff, 1'b0};
               bit_in = 4'd0;
               phase_in = PH_AW_TXL;
            end
            PH_R_PREP: phase_in = PH_SR_SETUP;
            PH_SR_SETUP: phase_in = PH_SR_FALL;
            PH_SR_FALL: begin
               shift_in = {addr_ff, 1'b1};
               bit_in = 4'd0;
               phase_in = PH_AR_TXL;
            end
            PH_RX_LOW: phase_in = PH_RX_HIGH;
            PH_RX_HIGH: begin
               shift_in = {shift_ff[6:0], in_data.sda_in};
               bit_in = bit_ff + 4'd1;
               if (bit_ff >= 4'd7) begin
                  byte_in = byte_ff + 8'd1;
                  rsp_in.read_valid = 1'b1;
                  rsp_in.read_byte = {shift_ff[6:0], in_data.sda_in};
                  rsp_in.read_last = (byte_ff + 8'd1) >= rtot_ff;
                  phase_in = PH_MACK_LOW;
               end else begin
                  phase_in = PH_RX_LOW;
               end
            end
            PH_MACK_LOW: phase_in = PH_MACK_HIGH;
            PH_MACK_HIGH: begin
               if (byte_ff >= rtot_ff) begin
                  shift_in = 8'd0;
                  phase_in = PH_STOP_LOW;
               end else begin
                  shift_in = 8'd0;
                  bit_in = 4'd0;
                  phase_in = PH_RX_LOW;
               end
            end
            PH_STOP_LOW: phase_in = PH_STOP_HIGH;
            PH_STOP_HIGH: phase_in = PH_STOP_RISE;
            PH_STOP_RISE: begin
               rsp_in.done_res = 1'b1;
               rsp_in.status = shift_ff[1:0];
               fill_in = 8'd0;
               phase_in = PH_IDLE;
            end
            PH_AW_TXL, PH_D_TXL, PH_AR_TXL: phase_in = phase_type'(phase_ff + 5'd1);
            PH_AW_TXH, PH_D_TXH, PH_AR_TXH: begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in = bit_ff + 4'd1;
               phase_in = (bit_ff >= 4'd7) ? phase_type'(phase_ff + 5'd1)
                                           : phase_type'(phase_ff - 5'd1);
            end
            PH_AW_ACKL, PH_D_ACKL, PH_AR_ACKL: begin
               wait_in = 8'd0;
               phase_in = phase_type'(phase_ff + 5'd1);
            end
            PH_AR_HOLD: begin
               byte_in = 8'd0;
               shift_in = 8'd0;
               bit_in = 4'd0;
               phase_in = PH_RX_LOW;
            end
            PH_AW_HOLD, PH_D_HOLD: begin
               pre_rd = 1'b1;
               if (phase_ff == PH_D_HOLD) begin
                  byte_in = byte_ff + 8'd1;
               end
               if (byte_in < wtot_ff) begin
                  shift_in = mem_rd_ff;
                  bit_in = 4'd0;
                  delay_in = 8'd0;
                  phase_in = PH_D_TXL;
               end else if (rtot_ff != 8'd0) begin
                  phase_in = PH_R_PREP;
               end else begin
                  shift_in = 8'd0;
                  delay_in = 8'd0;
                  phase_in = PH_STOP_LOW;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      case (phase_in)
         PH_IDLE: pins = 3'd3;
         PH_SW_SETUP, PH_SR_SETUP: pins = 3'd7;
         PH_SW_FALL, PH_SR_FALL: pins = 3'd5;
         PH_R_PREP: pins = 3'd6;
         PH_RX_LOW: pins = 3'd2;
         PH_RX_HIGH: pins = 3'd3;
         PH_MACK_LOW: pins = (byte_in >= rtot_in) ? 3'd6 : 3'd4;
         PH_MACK_HIGH: pins = (byte_in >= rtot_in) ? 3'd7 : 3'd5;
         PH_STOP_LOW: pins = 3'd4;
         PH_STOP_HIGH: pins = 3'd5;
         PH_STOP_RISE: pins = 3'd7;
         PH_AW_TXL, PH_D_TXL, PH_AR_TXL: pins = {1'b1, shift_in[7], 1'b0};
         PH_AW_TXH, PH_D_TXH, PH_AR_TXH: pins = {1'b1, shift_in[7], 1'b1};
         PH_AW_ACKL, PH_D_ACKL, PH_AR_ACKL: pins = 3'd2;
         default: pins = 3'd3;
      endcase
      rsp_in.scl_out = pins[0];
      rsp_in.sda_out = pins[1];
      rsp_in.sda_drive = pins[2];
      rsp_in.busy_res = phase_in != PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= 8'd0;
         byte_ff <= 8'd0;
         shift_ff <= 8'd0;
         wait_ff <= 8'd0;
         fill_ff <= 8'd0;
         wtot_ff <= 8'd0;
         rtot_ff <= 8'd0;
         bit_ff <= 4'd0;
         addr_ff <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            delay_ff <= delay_in;
            byte_ff <= byte_in;
            shift_ff <= shift_in;
            wait_ff <= wait_in;
            fill_ff <= fill_in;
            wtot_ff <= wtot_in;
            rtot_ff <= rtot_in;
            bit_ff <= bit_in;
            addr_ff <= addr_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step && rsp_in.done_res) |=> phase_ff == PH_IDLE) else $error("done not idle");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> fill_ff <= BUF_DEPTH_B) else $error("fill overrun");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_take && !step) |=> $stable(rsp_ff)) else $error("rsp changed");
   a_rd_ok: assert property (@(posedge clock) disable iff (reset)
      (pre_rd && rd_ok) |-> wtot_ff != 8'd0) else $error("buffer read");
endmodule

@@ tb/i2c_master_transaction_engine_tb.sv @@
// Testbench for the I2C master transaction engine: drives tick, load, start, NOP and random
// beats and CSR writes, predicts every response beat with an in-bench bus sequencer and checks
// them in order. Depends on i2cm_pkg and the i2c_master_transaction_engine top level.
module i2c_master_transaction_engine_tb;
   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int ROLE_AW = 0, ROLE_D = 1, ROLE_AR = 2, ROLE_NONE = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   req_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = CSR_DELAY;
   logic [7:0] csr_data = '0;

   i2c_master_transaction_engine dut (.*);

   always #5 clock = ~clock;

   int cycle_count = 0;
   int error_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   rsp_type expected_q[$];

   // Bus sequencer state mirrored in the bench.
   logic [7:0] delay_cfg = 8'd1, timeout_cfg = ACK_TIMEOUT_RST;
   phase_type seq_phase = PH_IDLE;
   logic [7:0] delay_cnt, byte_cnt, shifter, ack_wait, fill_cnt, writes_tot, reads_tot;
   logic [3:0] bit_cnt;
   logic [6:0] target;
   logic [7:0] wbuf [BUF_DEPTH];
   logic got_valid, got_last, got_done;
   logic [7:0] got_byte;
   logic [1:0] got_status;

   function automatic bit quiet_window();
      return cycle_count > 1000 && cycle_count < 1300;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic begin_tx(input int role, input logic [7:0] b);
      shifter = b;
      bit_cnt = '0;
      delay_cnt = '0;
      seq_phase = phase_type'(int'(PH_AW_TXL) + role * 5);
   endtask

   task automatic begin_stop(input logic [1:0] code);
      shifter = {6'd0, code};
      delay_cnt = '0;
      seq_phase = PH_STOP_LOW;
   endtask

   task automatic begin_rx();
      shifter = '0;
      bit_cnt = '0;
      seq_phase = PH_RX_LOW;
   endtask

   task automatic advance_phase(input logic sda);
      int rel, role, stp;
      case (seq_phase)
         PH_SW_SETUP: seq_phase = PH_SW_FALL;
         PH_SW_FALL: begin_tx(ROLE_AW, {target, 1'b0});
         PH_R_PREP: seq_phase = PH_SR_SETUP;
         PH_SR_SETUP: seq_phase = PH_SR_FALL;
         PH_SR_FALL: begin_tx(ROLE_AR, {target, 1'b1});
         PH_RX_LOW: seq_phase = PH_RX_HIGH;
         PH_RX_HIGH: begin
            shifter = {shifter[6:0], sda};
            bit_cnt++;
            if (bit_cnt >= 4'd8) begin
               byte_cnt++;
               got_valid = 1'b1;
               got_byte = shifter;
               got_last = byte_cnt >= reads_tot;
               seq_phase = PH_MACK_LOW;
            end else begin
               seq_phase = PH_RX_LOW;
            end
         end
         PH_MACK_LOW: seq_phase = PH_MACK_HIGH;
         PH_MACK_HIGH: begin
            if (byte_cnt >= reads_tot) begin_stop(2'd0);
            else begin_rx();
         end
         PH_STOP_LOW: seq_phase = PH_STOP_HIGH;
         PH_STOP_HIGH: seq_phase = PH_STOP_RISE;
         PH_STOP_RISE: begin
            got_done = 1'b1;
            got_status = shifter[1:0];
            fill_cnt = '0;
            seq_phase = PH_IDLE;
         end
         default: begin
            rel = int'(seq_phase) - int'(PH_AW_TXL);
            role = rel / 5;
            stp = rel % 5;
            if (stp == 0) begin
               seq_phase = phase_type'(seq_phase + 1);
            end else if (stp == 1) begin
               shifter = shifter << 1;
               bit_cnt++;
               seq_phase = phase_type'(bit_cnt >= 4'd8 ? seq_phase + 1 : seq_phase - 1);
            end else if (stp == 2) begin
               ack_wait = '0;
               seq_phase = phase_type'(seq_phase + 1);
            end else if (stp == 4) begin
               if (role == ROLE_AR) begin
                  byte_cnt = '0;
                  begin_rx();
               end else begin
                  if (role == ROLE_D) byte_cnt++;
                  if (byte_cnt < writes_tot) begin_tx(ROLE_D, wbuf[byte_cnt[BUF_AW-1:0]]);
                  else if (reads_tot != 0) seq_phase = PH_R_PREP;
                  else begin_stop(2'd0);
               end
            end
         end
      endcase
   endtask

   function automatic int wait_role();
      int rel;
      rel = int'(seq_phase) - int'(PH_AW_TXL);
      if (seq_phase >= PH_AW_TXL && seq_phase < PH_MACK_LOW && rel % 5 == 3) return rel / 5;
      return ROLE_NONE;
   endfunction

   task automatic bus_tick(input logic sda);
      int role;
      if (seq_phase == PH_IDLE) return;
      role = wait_role();
      if (role != ROLE_NONE) begin
         if (!sda) begin
            ack_wait = '0;
            delay_cnt = '0;
            seq_phase = phase_type'(seq_phase + 1);
         end else if (ack_wait >= timeout_cfg) begin
            ack_wait = '0;
            begin_stop(2'(role + 1));
         end else begin
            ack_wait++;
         end
         return;
      end
      delay_cnt++;
      if (delay_cnt < (delay_cfg == 0 ? 8'd1 : delay_cfg)) return;
      delay_cnt = '0;
      advance_phase(sda);
   endtask

   task automatic predict_beat(input req_type r);
      rsp_type o;
      logic [2:0] pins;
      int rel;
      got_valid = 1'b0; got_byte = '0; got_last = 1'b0; got_done = 1'b0; got_status = '0;
      case (func_type'(r.func))
         FUNC_TICK: bus_tick(r.sda_in);
         FUNC_LOAD: if (seq_phase == PH_IDLE && fill_cnt < BUF_DEPTH_B) begin
            wbuf[fill_cnt[BUF_AW-1:0]] = r.data_byte;
            fill_cnt++;
         end
         FUNC_START: if (seq_phase == PH_IDLE) begin
            target = r.dev_addr;
            writes_tot = r.wr_count > BUF_DEPTH_B ? BUF_DEPTH_B : r.wr_count;
            reads_tot = r.rd_count;
            delay_cnt = '0; bit_cnt = '0; byte_cnt = '0; shifter = '0; ack_wait = '0;
            seq_phase = PH_SW_SETUP;
         end
         default: ;
      endcase
      case (seq_phase)
         PH_IDLE, PH_RX_HIGH: pins = 3'd3;
         PH_SW_SETUP, PH_SR_SETUP, PH_STOP_RISE: pins = 3'd7;
         PH_SW_FALL, PH_SR_FALL, PH_STOP_HIGH: pins = 3'd5;
         PH_R_PREP: pins = 3'd6;
         PH_RX_LOW: pins = 3'd2;
         PH_MACK_LOW: pins = byte_cnt >= reads_tot ? 3'd6 : 3'd4;
         PH_MACK_HIGH: pins = byte_cnt >= reads_tot ? 3'd7 : 3'd5;
         PH_STOP_LOW: pins = 3'd4;
         default: begin
            rel = (int'(seq_phase) - int'(PH_AW_TXL)) % 5;
            if (rel == 0) pins = {1'b1, shifter[7], 1'b0};
            else if (rel == 1) pins = {1'b1, shifter[7], 1'b1};
            else if (rel == 2) pins = 3'd2;
            else pins = 3'd3;
         end
      endcase
      o.scl_out = pins[0];
      o.sda_out = pins[1];
      o.sda_drive = pins[2];
      o.busy_res = seq_phase != PH_IDLE;
      o.read_valid = got_valid;
      o.read_byte = got_byte;
      o.read_last = got_last;
      o.done_res = got_done;
      o.status = got_status;
      expected_q.push_back(o);
   endtask

   task automatic send_beat(input req_type r);
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      predict_beat(r);
      sent_count++;
      if (!quiet_window() && $urandom_range(99) < 32) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_func(input func_type f, input logic sda, input logic [7:0] b,
                            input logic [6:0] a, input logic [7:0] wl, input logic [7:0] rl);
      req_type r;
      r.func = f; r.sda_in = sda; r.data_byte = b;
      r.dev_addr = a; r.wr_count = wl; r.rd_count = rl;
      send_beat(r);
   endtask

   task automatic send_noise();
      req_type r;
      r = req_type'({$urandom, $urandom});
      if (r.func == FUNC_START && seq_phase == PH_IDLE) begin
         r.wr_count = 8'($urandom_range(0, fill_cnt));
      end
      send_beat(r);
   endtask

   // One full bus transaction; the acknowledge-wait ticks it sends for role nack_role hold SDA high.
   task automatic run_transfer(input logic [6:0] addr, input int loads, input logic [7:0] wl,
                               input logic [7:0] rl, input int nack_role, input int noise_pct);
      int role;
      repeat (loads) begin
         send_func(FUNC_LOAD, 1'($urandom), 8'($urandom), 7'($urandom), 8'($urandom),
                   8'($urandom));
      end
      send_func(FUNC_START, 1'($urandom), 8'($urandom), addr, wl, rl);
      while (seq_phase != PH_IDLE) begin
         role = wait_role();
         if ($urandom_range(99) < noise_pct) send_noise();
         else if (role != ROLE_NONE)
            send_func(FUNC_TICK, role == nack_role ? 1'b1 : ($urandom_range(7) == 0),
                      8'($urandom), 7'($urandom), 8'($urandom), 8'($urandom));
         else send_func(FUNC_TICK, 1'($urandom), 8'($urandom), 7'($urandom), 8'($urandom),
                        8'($urandom));
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      req_push <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DELAY) delay_cfg = val;
      else timeout_cfg = val;
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_q.size() == 0) begin
            $error("response beat with nothing expected");
            error_count++;
         end else begin
            e = expected_q.pop_front();
            check_field("scl_out", int'(e.scl_out), int'(rsp_data.scl_out));
            check_field("sda_out", int'(e.sda_out), int'(rsp_data.sda_out));
            check_field("sda_drive", int'(e.sda_drive), int'(rsp_data.sda_drive));
            check_field("busy_res", int'(e.busy_res), int'(rsp_data.busy_res));
            check_field("read_valid", int'(e.read_valid), int'(rsp_data.read_valid));
            check_field("read_byte", int'(e.read_byte), int'(rsp_data.read_byte));
            check_field("read_last", int'(e.read_last), int'(rsp_data.read_last));
            check_field("done_res", int'(e.done_res), int'(rsp_data.done_res));
            check_field("status", int'(e.status), int'(rsp_data.status));
         end
         checked_count++;
      end
   end

   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (!hold_done && checked_count >= 400) begin
         hold_done <= 1'b1;
         hold_left <= 300;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= quiet_window() || $urandom_range(99) >= 24;
      end
   end

   task automatic test_defaults();
      run_transfer(7'h00, 2, 8'd2, 8'd1, ROLE_NONE, 0);
      run_transfer(7'h7f, 1, 8'd1, 8'd0, ROLE_NONE, 0);
      run_transfer(7'h55, 0, 8'd0, 8'd2, ROLE_NONE, 0);
   endtask

   task automatic test_nack();
      run_transfer(7'h2a, 1, 8'd1, 8'd1, ROLE_AW, 0);
      run_transfer(7'h15, 2, 8'd2, 8'd1, ROLE_D, 0);
      run_transfer(7'h33, 1, 8'd1, 8'd1, ROLE_AR, 0);
   endtask

   task automatic test_extremes();
      write_csr(CSR_DELAY, 8'd0);
      write_csr(CSR_TIMEOUT, 8'd0);
      run_transfer(7'h41, 130, 8'd200, 8'd2, ROLE_D, 0);
      run_transfer(7'h12, 0, 8'd0, 8'd0, ROLE_AW, 0);
      write_csr(CSR_TIMEOUT, 8'd255);
      run_transfer(7'h6c, 1, 8'd1, 8'd0, ROLE_AW, 0);
      write_csr(CSR_DELAY, 8'd7);
      run_transfer(7'h01, 0, 8'd0, 8'd0, ROLE_NONE, 0);
      write_csr(CSR_DELAY, 8'd1);
      write_csr(CSR_TIMEOUT, ACK_TIMEOUT_RST);
      send_func(FUNC_NOP, 1'b1, 8'hff, 7'h7f, 8'hff, 8'hff);
      send_func(FUNC_TICK, 1'b1, 8'h00, 7'h00, 8'h00, 8'h00);
   endtask

   task automatic test_random();
      int role;
      logic [7:0] wl;
      while (sent_count < 1200) begin
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
               0: write_csr(CSR_DELAY, 8'($urandom_range(0, 3)));
               1: write_csr(CSR_TIMEOUT, 8'($urandom_range(0, 20)));
               default: write_csr(CSR_TIMEOUT, ACK_TIMEOUT_RST);
            endcase
         end
         role = $urandom_range(9) == 0 ? $urandom_range(0, 2) : ROLE_NONE;
         if ($urandom_range(4) == 0) repeat ($urandom_range(1, 6)) send_noise();
         wl = 8'($urandom_range(0, 3));
         if (wl > fill_cnt) wl = fill_cnt;
         run_transfer(7'($urandom), $urandom_range(0, 4), wl, 8'($urandom_range(0, 3)),
                      role, 5);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_nack();
      test_extremes();
      test_random();
      req_push <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ i2c_master_transaction_engine.f @@
hdl/i2cm_pkg.sv
hdl/i2cm_queue.sv
hdl/i2cm_seq.sv
hdl/i2c_master_transaction_engine.sv
tb/i2c_master_transaction_engine_tb.sv
